>>> design/ihex_pkg.sv
// Package for the Intel HEX record decoder.
// Holds the phase and kind codes, the character constants and the result struct.
// Depends on nothing; every other design file uses it by scoped names.
package ihex_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_ADDR = 3'd2,
        PH_TYPE = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_BASE = 2'd1,
        KIND_EOF  = 2'd2,
        KIND_BAD  = 2'd3
    } t_kind;

    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_F   = 8'h46;
    localparam logic [7:0] DIGIT_TEN   = 8'h0A;

    localparam logic [7:0] TYPE_DATA   = 8'h00;
    localparam logic [7:0] TYPE_EOF    = 8'h01;
    localparam logic [7:0] TYPE_SEG    = 8'h02;
    localparam logic [7:0] TYPE_LINEAR = 8'h04;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
    } t_result;

endpackage

>>> design/ihex_if.sv
// Handshake interfaces for the Intel HEX record decoder.
// One carries a character word in, the other a decoded record word out.
// Depends on ihex_pkg for the kind code type.
interface ihex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface ihex_rec_if;
    logic            valid;
    logic            ready;
    ihex_pkg::t_kind kind;
    logic [31:0]     address;
    logic [7:0]      data_byte;

    modport source (output valid, output kind, output address, output data_byte, input ready);
    modport sink   (input valid, input kind, input address, input data_byte, output ready);
endinterface

>>> design/intel_hex_record_decoder_top.sv
// Top level of the Intel HEX record decoder.
// Input word register, record parser core and output word register.
// Depends on ihex_pkg, ihex_if and ihex_core.
//
// The block takes Intel HEX text one character word per cycle on i_char and
// gives decoded record words on o_rec: data bytes with their full 32-bit
// address, a new base address for record types 02 to 04, end of file, and
// a bad digit report for a non-hex character inside a record.
// An accepted character is held in the input register; when it advances, the
// parser state updates and any result loads the output register. Throughput
// is one character per cycle while the output is not stalled; most characters
// give no result. When the receiver stalls, the output register holds its
// word and the input register still takes a character if it is empty, after
// which i_char.ready drops until the output word is taken.
// Reset is synchronous and active low: it empties both registers and puts
// the parser back to hunting for a colon with the upper address cleared.
module intel_hex_record_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ihex_char_if.sink   i_char,
    ihex_rec_if.source  o_rec
);

    logic              r_in_valid;
    logic [7:0]        r_char;
    logic              r_out_valid;
    ihex_pkg::t_kind   r_kind;
    logic [31:0]       r_address;
    logic [7:0]        r_data_byte;
    logic              w_advance;
    ihex_pkg::t_result w_res;

    assign w_advance    = r_in_valid && (!r_out_valid || o_rec.ready);
    assign i_char.ready = !r_in_valid || w_advance;

    ihex_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_char    (r_char),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.char_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res.valid;
        end else if (o_rec.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_res.valid) begin
            r_kind      <= w_res.kind;
            r_address   <= w_res.address;
            r_data_byte <= w_res.data_byte;
        end
    end

    assign o_rec.valid     = r_out_valid;
    assign o_rec.kind      = r_kind;
    assign o_rec.address   = r_address;
    assign o_rec.data_byte = r_data_byte;

endmodule

>>> design/ihex_digit.sv
// Hex digit decoder for the Intel HEX record decoder.
// Maps one ASCII character to a nibble value and a flag for a valid digit.
// Depends on ihex_pkg for the character constants.
module ihex_digit (
    input  logic [7:0] i_char,
    output logic       o_ok,
    output logic [3:0] o_value
);

    logic [7:0] w_value;

    always_comb begin
        o_ok    = 1'b1;
        w_value = 8'h00;
        if (i_char >= ihex_pkg::CHAR_ZERO && i_char <= ihex_pkg::CHAR_NINE) begin
            w_value = i_char - ihex_pkg::CHAR_ZERO;
        end else if (i_char >= ihex_pkg::CHAR_LOW_A && i_char <= ihex_pkg::CHAR_LOW_F) begin
            w_value = i_char - ihex_pkg::CHAR_LOW_A + ihex_pkg::DIGIT_TEN;
        end else if (i_char >= ihex_pkg::CHAR_UP_A && i_char <= ihex_pkg::CHAR_UP_F) begin
            w_value = i_char - ihex_pkg::CHAR_UP_A + ihex_pkg::DIGIT_TEN;
        end else begin
            o_ok = 1'b0;
        end
        o_value = w_value[3:0];
    end

endmodule

>>> design/ihex_core.sv
// Record parser state for the Intel HEX record decoder.
// Holds the phase and record fields and forms the result for one character.
// Depends on ihex_pkg and ihex_digit.
module ihex_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [7:0]        i_char,
    output ihex_pkg::t_result o_res
);

    ihex_pkg::t_phase r_phase, n_phase;
    logic             r_pending, n_pending;
    logic [3:0]       r_high, n_high;
    logic             r_fbi, n_fbi;
    logic [7:0]       r_len, n_len;
    logic [15:0]      r_addr, n_addr;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_count, n_count;
    logic [15:0]      r_upper, n_upper;
    logic [15:0]      r_acc, n_acc;

    logic             w_ok;
    logic [3:0]       w_val;
    logic [7:0]       w_byte;
    logic [7:0]       w_fin_type;
    logic [15:0]      w_fin_acc;
    logic             w_finish;
    logic [15:0]      w_low;

    ihex_digit u_digit (
        .i_char  (i_char),
        .o_ok    (w_ok),
        .o_value (w_val)
    );

    assign w_byte = {r_high, w_val};
    assign w_low  = r_addr + {8'h00, r_count};

    always_comb begin
        n_phase    = r_phase;
        n_pending  = r_pending;
        n_high     = r_high;
        n_fbi      = r_fbi;
        n_len      = r_len;
        n_addr     = r_addr;
        n_type     = r_type;
        n_count    = r_count;
        n_upper    = r_upper;
        n_acc      = r_acc;
        w_finish   = 1'b0;
        w_fin_type = r_type;
        w_fin_acc  = r_acc;
        o_res      = '0;
        if (r_phase == ihex_pkg::PH_HUNT) begin
            if (i_char == ihex_pkg::CHAR_COLON) begin
                n_phase   = ihex_pkg::PH_LEN;
                n_pending = 1'b0;
                n_fbi     = 1'b0;
                n_count   = 8'h00;
                n_acc     = 16'h0000;
            end
        end else if (!w_ok) begin
            n_phase    = ihex_pkg::PH_HUNT;
            n_pending  = 1'b0;
            o_res.valid = 1'b1;
            o_res.kind  = ihex_pkg::KIND_BAD;
        end else if (!r_pending) begin
            n_high    = w_val;
            n_pending = 1'b1;
        end else begin
            n_pending = 1'b0;
            unique case (r_phase)
                ihex_pkg::PH_LEN: begin
                    n_len   = w_byte;
                    n_fbi   = 1'b0;
                    n_phase = ihex_pkg::PH_ADDR;
                end
                ihex_pkg::PH_ADDR: begin
                    if (!r_fbi) begin
                        n_addr = {w_byte, 8'h00};
                        n_fbi  = 1'b1;
                    end else begin
                        n_addr  = {r_addr[15:8], w_byte};
                        n_fbi   = 1'b0;
                        n_phase = ihex_pkg::PH_TYPE;
                    end
                end
                ihex_pkg::PH_TYPE: begin
                    n_type     = w_byte;
                    n_count    = 8'h00;
                    w_fin_type = w_byte;
                    if (r_len == 8'h00) begin
                        w_finish = 1'b1;
                    end else begin
                        n_phase = ihex_pkg::PH_DATA;
                    end
                end
                ihex_pkg::PH_DATA: begin
                    n_acc     = {r_acc[7:0], w_byte};
                    n_count   = r_count + 8'h01;
                    w_fin_acc = n_acc;
                    if (r_type == ihex_pkg::TYPE_DATA) begin
                        o_res.valid     = 1'b1;
                        o_res.kind      = ihex_pkg::KIND_DATA;
                        o_res.address   = {r_upper, w_low};
                        o_res.data_byte = w_byte;
                        if (n_count == r_len) begin
                            n_phase = ihex_pkg::PH_SUM;
                        end
                    end else if (n_count == r_len) begin
                        w_finish = 1'b1;
                    end
                end
                default: begin
                    n_phase = ihex_pkg::PH_HUNT;
                end
            endcase
        end
        if (w_finish) begin
            n_phase = ihex_pkg::PH_SUM;
            if (w_fin_type == ihex_pkg::TYPE_EOF) begin
                o_res.valid = 1'b1;
                o_res.kind  = ihex_pkg::KIND_EOF;
            end else if (w_fin_type >= ihex_pkg::TYPE_SEG
                         && w_fin_type <= ihex_pkg::TYPE_LINEAR) begin
                n_upper       = w_fin_acc;
                o_res.valid   = 1'b1;
                o_res.kind    = ihex_pkg::KIND_BASE;
                o_res.address = {w_fin_acc, 16'h0000};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ihex_pkg::PH_HUNT;
            r_pending <= 1'b0;
            r_high    <= 4'h0;
            r_fbi     <= 1'b0;
            r_len     <= 8'h00;
            r_addr    <= 16'h0000;
            r_type    <= 8'h00;
            r_count   <= 8'h00;
            r_upper   <= 16'h0000;
            r_acc     <= 16'h0000;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_high    <= n_high;
            r_fbi     <= n_fbi;
            r_len     <= n_len;
            r_addr    <= n_addr;
            r_type    <= n_type;
            r_count   <= n_count;
            r_upper   <= n_upper;
            r_acc     <= n_acc;
        end
    end

endmodule

>>> design/ihex_checker.sv
// Port checker for the Intel HEX record decoder.
// Watches the top level's channels over time; bound to the top level below.
// Depends on ihex_pkg and intel_hex_record_decoder_top.
module ihex_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input ihex_pkg::t_kind i_kind,
    input logic [31:0]     i_address,
    input logic [7:0]      i_data_byte
);

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
                && $stable(i_address) && $stable(i_data_byte);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("stalled output word changed");

    property p_reset_empty;
        @(posedge i_clk) !i_rst_n |=> !i_out_valid && i_in_ready;
    endproperty
    a_reset_empty: assert property (p_reset_empty) else $error("not empty after reset");

    property p_plain_kinds;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_out_valid && (i_kind == ihex_pkg::KIND_EOF || i_kind == ihex_pkg::KIND_BAD)
            |-> i_address == 32'h0 && i_data_byte == 8'h00;
    endproperty
    a_plain_kinds: assert property (p_plain_kinds) else $error("stray payload on status word");

    property p_base_aligned;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_out_valid && i_kind == ihex_pkg::KIND_BASE
            |-> i_address[15:0] == 16'h0 && i_data_byte == 8'h00;
    endproperty
    a_base_aligned: assert property (p_base_aligned) else $error("base word not aligned");

    property p_no_result_without_input;
        @(posedge i_clk) disable iff (!i_rst_n)
            $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2)
                || !$past(i_in_ready);
    endproperty
    a_no_result_without_input: assert property (p_no_result_without_input)
        else $error("result word without a character");

endmodule

bind intel_hex_record_decoder_top ihex_checker u_ihex_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_char.valid),
    .i_in_ready  (i_char.ready),
    .i_out_valid (o_rec.valid),
    .i_out_ready (o_rec.ready),
    .i_kind      (o_rec.kind),
    .i_address   (o_rec.address),
    .i_data_byte (o_rec.data_byte)
);
